// File: hw/rtl/ssfe_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment frame encoder package
// Shared types, symbol codes, bus bytes and segment lookup functions.
// ----------------------------------------------------------------------------
package ssfe_pkg;

   localparam int DIGIT_COUNT     = 4;
   // Start, data command, stop, start and address byte precede the digits; a stop follows.
   localparam int FRAME_LEN       = DIGIT_COUNT + 6;
   localparam int FIRST_DIGIT_IDX = 5;
   localparam int IDX_W           = $clog2(FRAME_LEN);
   localparam int POS_W           = $clog2(DIGIT_COUNT);
   localparam int CNT_W           = $clog2(DIGIT_COUNT + 1);

   // Request codes.
   localparam logic [1:0] CMD_DECIMAL = 2'd0;
   localparam logic [1:0] CMD_CHARS   = 2'd1;
   localparam logic [1:0] CMD_BRIGHT  = 2'd2;

   // Bus symbol kinds.
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_STOP  = 2'd2;

   // Bus bytes.
   localparam logic [7:0] BYTE_DATA_CMD    = 8'h40;
   localparam logic [7:0] BYTE_ADDR_CMD    = 8'hC0;
   localparam logic [7:0] BYTE_BRIGHT_BASE = 8'h87;
   localparam logic [7:0] SEG_BLANK        = 8'h00;
   localparam logic [7:0] SEG_UNKNOWN      = 8'b0000_1100;
   localparam logic [7:0] SEG_DOT          = 8'h80;
   localparam logic [3:0] BRIGHT_MAX       = 4'd8;

   // floor(x / 10) equals (x * RECIP10) >> RECIP_SHIFT for every 14-bit x.
   localparam logic [16:0] RECIP10     = 17'd52429;
   localparam int          RECIP_SHIFT = 19;

   typedef struct packed {
      logic [1:0]  command;
      logic [13:0] number_value;
      logic        show_separator;
      logic [2:0]  char_count;
      logic [7:0]  char_first;
      logic [7:0]  char_second;
      logic [7:0]  char_third;
      logic [7:0]  char_fourth;
      logic [3:0]  brightness_level;
   } ssfe_req_type;

   typedef struct packed {
      logic [1:0] symbol_kind;
      logic [7:0] data_byte;
      logic       last_symbol;
   } ssfe_rsp_type;

   // Segment pattern of a hex digit, segment A in bit 0.
   function automatic logic [7:0] hex_to_seg(input logic [3:0] nib);
      logic [7:0] seg;
      unique case (nib)
         4'h0: seg = 8'b0011_1111;
         4'h1: seg = 8'h06;
         4'h2: seg = 8'h5B;
         4'h3: seg = 8'h4F;
         4'h4: seg = 8'h66;
         4'h5: seg = 8'h6D;
         4'h6: seg = 8'h7D;
         4'h7: seg = 8'h07;
         4'h8: seg = 8'h7F;
         4'h9: seg = 8'h6F;
         4'hA: seg = 8'h77;
         4'hB: seg = 8'h7C;
         4'hC: seg = 8'h39;
         4'hD: seg = 8'h5E;
         4'hE: seg = 8'h79;
         4'hF: seg = 8'h71;
      endcase
      return seg;
   endfunction

   // Digits and lower-case a to f show as hex, space is blank, anything else
   // shows the unknown-character pattern.
   function automatic logic [7:0] char_to_seg(input logic [7:0] code);
      logic [7:0] seg;
      if (code >= "0" && code <= "9") begin
         seg = hex_to_seg(code[3:0]);
      end else if (code >= "a" && code <= "f") begin
         seg = hex_to_seg(code[3:0] + 4'd9);
      end else if (code == " ") begin
         seg = SEG_BLANK;
      end else begin
         seg = SEG_UNKNOWN;
      end
      return seg;
   endfunction

endpackage

// File: hw/rtl/seven_segment_frame_encoder.sv
// ----------------------------------------------------------------------------
// Seven-segment frame encoder
// Turns display and brightness requests into two-wire bus symbol sequences.
// ----------------------------------------------------------------------------
// The req_ channel takes one request per transaction: a decimal value, up to
// four characters, or a brightness level. The rsp_ channel returns the bus
// symbols for that request one per transaction, start, data byte or stop,
// with last_symbol marking the final symbol of the request.
// A display request gives ten symbols and a brightness request three; an
// unknown command gives none. The output register moves one symbol per
// cycle when the receiver does not stall. After a request is accepted, the
// sequencer registers it and then loads its first symbol into the output
// register. The next request is accepted in the same cycle in which the last
// symbol of the current one is loaded into the output register, so frames
// follow each other without gaps.
// Decimal digits are extracted one per cycle, lowest first, during the five
// header symbols, by a reciprocal multiply.
// Reset clears the sequencer and drops rsp_valid. When the receiver stalls,
// the held symbol stays on rsp_payload and the sequencer waits behind it.
// ----------------------------------------------------------------------------
module seven_segment_frame_encoder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ssfe_pkg::ssfe_req_type req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ssfe_pkg::ssfe_rsp_type rsp_payload
);
   import ssfe_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 bright_ff, bright_in;
   logic                 sep_ff, sep_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [13:0]          value_ff, value_in;
   logic [CNT_W-1:0]     conv_ff, conv_in;
   logic [7:0]           dig_ff [DIGIT_COUNT];
   logic [7:0]           dig_in [DIGIT_COUNT];
   logic [7:0]           bright_byte_ff, bright_byte_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ssfe_rsp_type         rsp_ff, rsp_in;

   ssfe_rsp_type         sym;
   logic                 advance;
   logic                 req_fire;
   logic [IDX_W-1:0]     pos_wide;
   logic [POS_W-1:0]     pos;

   logic [7:0]           codes [DIGIT_COUNT];
   logic [7:0]           char_seg [DIGIT_COUNT];
   logic [DIGIT_COUNT-1:0] char_ok;
   logic [2:0]           count_clamped;
   logic                 ended;
   logic [3:0]           level_clamped;

   logic [30:0]          prod;
   logic [13:0]          quot;
   logic [13:0]          ten_quot;
   logic [13:0]          rem_wide;
   logic [POS_W-1:0]     conv_pos;

   // Symbol at the current sequence position.
   assign pos_wide = idx_ff - IDX_W'(FIRST_DIGIT_IDX);
   assign pos      = pos_wide[POS_W-1:0];

   always_comb begin
      sym = '0;
      if (bright_ff) begin
         priority if (idx_ff == IDX_W'(0)) begin
            sym.symbol_kind = KIND_START;
         end else if (idx_ff == IDX_W'(1)) begin
            sym.symbol_kind = KIND_DATA;
            sym.data_byte   = bright_byte_ff;
         end else begin
            sym.symbol_kind = KIND_STOP;
            sym.last_symbol = 1'b1;
         end
      end else begin
         priority if (idx_ff == IDX_W'(0) || idx_ff == IDX_W'(3)) begin
            sym.symbol_kind = KIND_START;
         end else if (idx_ff == IDX_W'(1)) begin
            sym.symbol_kind = KIND_DATA;
            sym.data_byte   = BYTE_DATA_CMD;
         end else if (idx_ff == IDX_W'(2)) begin
            sym.symbol_kind = KIND_STOP;
         end else if (idx_ff == IDX_W'(4)) begin
            sym.symbol_kind = KIND_DATA;
            sym.data_byte   = BYTE_ADDR_CMD;
         end else if (idx_ff == IDX_W'(FRAME_LEN - 1)) begin
            sym.symbol_kind = KIND_STOP;
            sym.last_symbol = 1'b1;
         end else begin
            sym.symbol_kind = KIND_DATA;
            sym.data_byte   = dig_ff[pos] |
                              ((sep_ff && pos == POS_W'(1)) ? SEG_DOT : SEG_BLANK);
         end
      end
   end

   assign advance   = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !busy_ff || (advance && sym.last_symbol);
   assign req_fire  = req_valid && req_ready;

   // Character positions: a zero code or the end of the count blanks the rest.
   assign codes[0] = req_payload.char_first;
   assign codes[1] = req_payload.char_second;
   assign codes[2] = req_payload.char_third;
   assign codes[3] = req_payload.char_fourth;
   assign count_clamped = (req_payload.char_count > 3'(DIGIT_COUNT)) ?
                          3'(DIGIT_COUNT) : req_payload.char_count;

   always_comb begin
      ended = 1'b0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (3'(i) >= count_clamped || codes[i] == 8'd0) begin
            ended = 1'b1;
         end
         char_ok[i]  = !ended;
         char_seg[i] = ended ? SEG_BLANK : char_to_seg(codes[i]);
      end
   end

   assign level_clamped = (req_payload.brightness_level > BRIGHT_MAX) ?
                          BRIGHT_MAX : req_payload.brightness_level;

   // One decimal digit per cycle: quotient by reciprocal, remainder by shift-add.
   assign prod     = {17'd0, value_ff} * {14'd0, RECIP10};
   assign quot     = {2'd0, prod[30:RECIP_SHIFT]};
   assign ten_quot = (quot << 3) + (quot << 1);
   assign rem_wide = value_ff - ten_quot;
   assign conv_pos = POS_W'(DIGIT_COUNT - 1) - conv_ff[POS_W-1:0];

   always_comb begin
      busy_in        = busy_ff;
      bright_in      = bright_ff;
      sep_in         = sep_ff;
      idx_in         = idx_ff;
      value_in       = value_ff;
      conv_in        = conv_ff;
      dig_in         = dig_ff;
      bright_byte_in = bright_byte_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;

      if (conv_ff < CNT_W'(DIGIT_COUNT)) begin
         dig_in[conv_pos] = hex_to_seg(rem_wide[3:0]);
         value_in         = quot;
         conv_in          = conv_ff + CNT_W'(1);
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = sym;
         idx_in       = idx_ff + IDX_W'(1);
         if (sym.last_symbol) begin
            busy_in = 1'b0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_fire) begin
         idx_in = '0;
         unique case (req_payload.command)
            CMD_DECIMAL: begin
               busy_in   = 1'b1;
               bright_in = 1'b0;
               sep_in    = req_payload.show_separator;
               value_in  = req_payload.number_value;
               conv_in   = '0;
            end
            CMD_CHARS: begin
               busy_in   = 1'b1;
               bright_in = 1'b0;
               sep_in    = req_payload.show_separator && char_ok[1];
               dig_in    = char_seg;
               conv_in   = CNT_W'(DIGIT_COUNT);
            end
            CMD_BRIGHT: begin
               busy_in        = 1'b1;
               bright_in      = 1'b1;
               bright_byte_in = BYTE_BRIGHT_BASE + {4'd0, level_clamped};
            end
            default: begin
               // Unknown command: the transaction is taken and produces no symbols.
               busy_in = busy_in;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         bright_ff    <= 1'b0;
         idx_ff       <= '0;
         conv_ff      <= CNT_W'(DIGIT_COUNT);
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         bright_ff    <= bright_in;
         idx_ff       <= idx_in;
         conv_ff      <= conv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sep_ff         <= sep_in;
      value_ff       <= value_in;
      dig_ff         <= dig_in;
      bright_byte_ff <= bright_byte_in;
      rsp_ff         <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: hw/rtl/ssfe_checker.sv
// ----------------------------------------------------------------------------
// Seven-segment frame encoder checker
// Port-level assertions on the symbol stream, bound to the top level.
// ----------------------------------------------------------------------------
module ssfe_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input ssfe_pkg::ssfe_rsp_type rsp_payload
);
   import ssfe_pkg::*;

   // A stalled transaction holds its symbol.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp payload changed while stalled");

   // Only data symbols carry a byte.
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.symbol_kind != KIND_DATA |-> rsp_payload.data_byte == 8'd0)
      else $error("non-data symbol carries a byte");

   // Every sequence ends on a stop condition.
   a_last_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last_symbol |-> rsp_payload.symbol_kind == KIND_STOP)
      else $error("last symbol is not a stop condition");

   // A delivered stop that ends a sequence is followed by a start or nothing.
   a_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_payload.last_symbol
      |=> !rsp_valid || rsp_payload.symbol_kind == KIND_START)
      else $error("sequence does not open with a start condition");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind seven_segment_frame_encoder ssfe_checker u_ssfe_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
